/* rtl/core/pit_pkg.sv */
`timescale 1ns / 1ps

package pit_pkg;

   localparam int COORD_WIDTH = 16;
   localparam int DIFF_WIDTH  = COORD_WIDTH + 1;
   localparam int PROD_WIDTH  = 2 * DIFF_WIDTH;
   localparam int CROSS_WIDTH = PROD_WIDTH + 1;

   localparam int NUM_REGS       = 6;
   localparam int CSR_ADDR_WIDTH = 3;

   localparam logic [CSR_ADDR_WIDTH-1:0] REG_VERTEX_A_X = 3'd0;
   localparam logic [CSR_ADDR_WIDTH-1:0] REG_VERTEX_A_Y = 3'd1;
   localparam logic [CSR_ADDR_WIDTH-1:0] REG_VERTEX_B_X = 3'd2;
   localparam logic [CSR_ADDR_WIDTH-1:0] REG_VERTEX_B_Y = 3'd3;
   localparam logic [CSR_ADDR_WIDTH-1:0] REG_VERTEX_C_X = 3'd4;
   localparam logic [CSR_ADDR_WIDTH-1:0] REG_VERTEX_C_Y = 3'd5;

   // sign of a cross product: neg set for negative, zero set for exactly zero
   typedef struct packed {
      logic neg;
      logic zero;
   } sign_type;

endpackage

/* rtl/core/pit_cross.sv */
`timescale 1ns / 1ps

// two-stage exact sign of ax*by - ay*bx
module pit_cross (
   input  logic                                     clock,
   input  logic                                     mul_en,
   input  logic                                     sub_en,
   input  logic signed [pit_pkg::DIFF_WIDTH-1:0]    ax,
   input  logic signed [pit_pkg::DIFF_WIDTH-1:0]    ay,
   input  logic signed [pit_pkg::DIFF_WIDTH-1:0]    bx,
   input  logic signed [pit_pkg::DIFF_WIDTH-1:0]    by,
   output pit_pkg::sign_type                        sign
);

   logic signed [pit_pkg::PROD_WIDTH-1:0]  p_ff, q_ff;
   logic signed [pit_pkg::PROD_WIDTH-1:0]  p_in, q_in;
   logic signed [pit_pkg::CROSS_WIDTH-1:0] cross_val;
   pit_pkg::sign_type                      sign_ff, sign_in;

   assign p_in = ax * by;
   assign q_in = ay * bx;

   assign cross_val = {p_ff[pit_pkg::PROD_WIDTH-1], p_ff} - {q_ff[pit_pkg::PROD_WIDTH-1], q_ff};

   always_comb begin
      sign_in.neg  = cross_val[pit_pkg::CROSS_WIDTH-1];
      sign_in.zero = (cross_val == '0);
   end

   always_ff @(posedge clock) begin
      if (mul_en) begin
         p_ff <= p_in;
         q_ff <= q_in;
      end
      if (sub_en) begin
         sign_ff <= sign_in;
      end
   end

   assign sign = sign_ff;

endmodule

/* rtl/core/point_in_triangle_test_unit.sv */
`timescale 1ns / 1ps

// Strict point-in-triangle test against a triangle held in six vertex registers.
// Configuration: csr_valid/csr_ready with csr_addr (0..5 = A.x, A.y, B.x, B.y,
// C.x, C.y) and csr_wdata; csr_ready is always high, other addresses are ignored.
// Vertices must be written only while the unit is idle; the unit does not
// enforce this. The orientation sign settles via the edge and u_cross_d registers.
// Request channel: req_valid/req_stall with req_point_x/req_point_y. A point is
// transferred when req_valid is high and req_stall is low.
// Response channel: rsp_valid/rsp_stall with rsp_inside_res and rsp_degenerate,
// one response per point, in order.
// A point is taken every cycle while req_stall is low. The pipeline is point
// differences, six 17x17 multiplies, three 35-bit subtracts to a sign, then the
// compare into the output register.
// When rsp_stall is high, empty stages still fill; req_stall rises only when
// every stage holds a point. Nothing is dropped or repeated.
// Reset (synchronous, active high) clears the vertices to zero and empties the
// pipeline.
module point_in_triangle_test_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [pit_pkg::CSR_ADDR_WIDTH-1:0]    csr_addr,
   input  logic [pit_pkg::COORD_WIDTH-1:0]       csr_wdata,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [pit_pkg::COORD_WIDTH-1:0] req_point_x,
   input  logic signed [pit_pkg::COORD_WIDTH-1:0] req_point_y,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic                                  rsp_inside_res,
   output logic                                  rsp_degenerate
);

   localparam int CW = pit_pkg::COORD_WIDTH;
   localparam int DW = pit_pkg::DIFF_WIDTH;

   logic signed [CW-1:0] vertex_a_x_ff, vertex_a_y_ff, vertex_b_x_ff;
   logic signed [CW-1:0] vertex_b_y_ff, vertex_c_x_ff, vertex_c_y_ff;

   // edge vectors of the configured triangle
   logic signed [DW-1:0] ba_x_ff, ba_y_ff, ca_x_ff, ca_y_ff;
   logic signed [DW-1:0] ba_x_in, ba_y_in, ca_x_in, ca_y_in;

   // point-side differences, first stage
   logic signed [DW-1:0] pa_x_ff, pa_y_ff, bp_x_ff, bp_y_ff, cp_x_ff, cp_y_ff;
   logic signed [DW-1:0] pa_x_in, pa_y_in, bp_x_in, bp_y_in, cp_x_in, cp_y_in;

   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, rsp_valid_ff;
   logic s1_valid_in, s2_valid_in, s3_valid_in, rsp_valid_in;
   logic load1, load2, load3, load_out;

   pit_pkg::sign_type sign_d, sign_u, sign_v, sign_w;

   logic rsp_inside_ff, rsp_degen_ff;
   logic rsp_inside_in, rsp_degen_in;

   function automatic logic signed [DW-1:0] sub_ext(input logic signed [CW-1:0] a,
                                                    input logic signed [CW-1:0] b);
      sub_ext = {a[CW-1], a} - {b[CW-1], b};
   endfunction

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         vertex_a_x_ff <= '0;
         vertex_a_y_ff <= '0;
         vertex_b_x_ff <= '0;
         vertex_b_y_ff <= '0;
         vertex_c_x_ff <= '0;
         vertex_c_y_ff <= '0;
      end else if (csr_valid) begin
         case (csr_addr)
            pit_pkg::REG_VERTEX_A_X: vertex_a_x_ff <= csr_wdata;
            pit_pkg::REG_VERTEX_A_Y: vertex_a_y_ff <= csr_wdata;
            pit_pkg::REG_VERTEX_B_X: vertex_b_x_ff <= csr_wdata;
            pit_pkg::REG_VERTEX_B_Y: vertex_b_y_ff <= csr_wdata;
            pit_pkg::REG_VERTEX_C_X: vertex_c_x_ff <= csr_wdata;
            pit_pkg::REG_VERTEX_C_Y: vertex_c_y_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // stage enables: a stage loads when empty or when its successor moves
   assign load_out  = !rsp_valid_ff || !rsp_stall;
   assign load3     = !s3_valid_ff || load_out;
   assign load2     = !s2_valid_ff || load3;
   assign load1     = !s1_valid_ff || load2;
   assign req_stall = !load1;

   assign s1_valid_in  = load1    ? req_valid   : s1_valid_ff;
   assign s2_valid_in  = load2    ? s1_valid_ff : s2_valid_ff;
   assign s3_valid_in  = load3    ? s2_valid_ff : s3_valid_ff;
   assign rsp_valid_in = load_out ? s3_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         s3_valid_ff  <= s3_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign ba_x_in = sub_ext(vertex_b_x_ff, vertex_a_x_ff);
   assign ba_y_in = sub_ext(vertex_b_y_ff, vertex_a_y_ff);
   assign ca_x_in = sub_ext(vertex_c_x_ff, vertex_a_x_ff);
   assign ca_y_in = sub_ext(vertex_c_y_ff, vertex_a_y_ff);

   assign pa_x_in = sub_ext(req_point_x, vertex_a_x_ff);
   assign pa_y_in = sub_ext(req_point_y, vertex_a_y_ff);
   assign bp_x_in = sub_ext(vertex_b_x_ff, req_point_x);
   assign bp_y_in = sub_ext(vertex_b_y_ff, req_point_y);
   assign cp_x_in = sub_ext(vertex_c_x_ff, req_point_x);
   assign cp_y_in = sub_ext(vertex_c_y_ff, req_point_y);

   always_ff @(posedge clock) begin
      ba_x_ff <= ba_x_in;
      ba_y_ff <= ba_y_in;
      ca_x_ff <= ca_x_in;
      ca_y_ff <= ca_y_in;
      if (load1) begin
         pa_x_ff <= pa_x_in;
         pa_y_ff <= pa_y_in;
         bp_x_ff <= bp_x_in;
         bp_y_ff <= bp_y_in;
         cp_x_ff <= cp_x_in;
         cp_y_ff <= cp_y_in;
      end
   end

   // free-running triangle orientation; vertices must only change when idle
   pit_cross u_cross_d (
      .clock  (clock),
      .mul_en (1'b1),
      .sub_en (1'b1),
      .ax     (ba_x_ff),
      .ay     (ba_y_ff),
      .bx     (ca_x_ff),
      .by     (ca_y_ff),
      .sign   (sign_d)
   );

   pit_cross u_cross_u (
      .clock  (clock),
      .mul_en (load2),
      .sub_en (load3),
      .ax     (ba_x_ff),
      .ay     (ba_y_ff),
      .bx     (pa_x_ff),
      .by     (pa_y_ff),
      .sign   (sign_u)
   );

   pit_cross u_cross_v (
      .clock  (clock),
      .mul_en (load2),
      .sub_en (load3),
      .ax     (pa_x_ff),
      .ay     (pa_y_ff),
      .bx     (ca_x_ff),
      .by     (ca_y_ff),
      .sign   (sign_v)
   );

   pit_cross u_cross_w (
      .clock  (clock),
      .mul_en (load2),
      .sub_en (load3),
      .ax     (bp_x_ff),
      .ay     (bp_y_ff),
      .bx     (cp_x_ff),
      .by     (cp_y_ff),
      .sign   (sign_w)
   );

   assign rsp_degen_in  = sign_d.zero;
   assign rsp_inside_in = !sign_d.zero && (sign_u == sign_d) && (sign_v == sign_d)
                          && (sign_w == sign_d);

   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_inside_ff <= rsp_inside_in;
         rsp_degen_ff  <= rsp_degen_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_inside_res = rsp_inside_ff;
   assign rsp_degenerate = rsp_degen_ff;

endmodule

/* rtl/core/pit_checker.sv */
`timescale 1ns / 1ps

module pit_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_stall,
   input logic rsp_valid,
   input logic rsp_stall,
   input logic rsp_inside_res,
   input logic rsp_degenerate
);

   logic idle_now;

   // no response held and no point taken in this cycle
   assign idle_now = !rsp_valid && !(req_valid && !req_stall);

   // a stalled response keeps its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_inside_res)
                                 && $stable(rsp_degenerate))
      else $error("stalled response changed");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_degenerate |-> !rsp_inside_res)
      else $error("inside reported for a degenerate triangle");

   // the request side only backs up when the response side is blocked
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid || !rsp_stall |-> !req_stall)
      else $error("request stalled while response side is free");

   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // quiet cycles spanning every stage leave the pipeline empty
   assert property (@(posedge clock) disable iff (reset)
      idle_now && $past(idle_now) && $past(idle_now, 2) && $past(idle_now, 3)
      |=> !rsp_valid)
      else $error("response appeared with no point in flight");

endmodule

bind point_in_triangle_test_unit pit_checker u_pit_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_inside_res (rsp_inside_res),
   .rsp_degenerate (rsp_degenerate)
);
